// ----- hdl/chb_pkg.sv -----
// Shared constants, codes and types for the cluster heartbeat membership block.
package chb_pkg;

    localparam int NODES_DEF  = 16;

    localparam int NODE_ID_W  = 4;
    localparam int STATUS_W   = 3;
    localparam int VERSION_W  = 32;
    localparam int TIMEOUT_W  = 16;
    localparam int CSIZE_W    = 5;
    localparam int COUNT_W    = 5;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [STATUS_W-1:0] ST_INITIAL  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RUNNING  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STOPPING = 3'd2;
    localparam logic [STATUS_W-1:0] ST_STARTING = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STANDBY  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ERRORED  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_TIMEDOUT = 3'd6;

    localparam logic OP_HEARTBEAT = 1'b0;
    localparam logic OP_TICK      = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MY_NODE_ID       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_SIZE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_VERSION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_MAIN       = 3'd4;

    localparam logic [NODE_ID_W-1:0] RST_MY_NODE_ID       = 4'd0;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT_TICKS    = 16'd121;
    localparam logic [CSIZE_W-1:0]   RST_CLUSTER_SIZE     = 5'd2;
    localparam logic [VERSION_W-1:0] RST_EXPECTED_VERSION = 32'd1;
    localparam logic                 RST_FORCE_MAIN       = 1'b0;

    localparam logic [COUNT_W-1:0] COUNT_SAT = 5'd31;

    typedef struct packed {
        logic                 op;
        logic [NODE_ID_W-1:0] node_id;
        logic [STATUS_W-1:0]  node_status;
        logic [VERSION_W-1:0] msg_version;
        logic [STATUS_W-1:0]  local_status;
    } t_in_item;

    typedef struct packed {
        logic               accepted;
        logic [COUNT_W-1:0] active_count;
        logic               svc_busy;
        logic               start_request;
        logic [COUNT_W-1:0] newly_timed_out;
    } t_out_item;

    typedef struct packed {
        logic [NODE_ID_W-1:0] my_node_id;
        logic [TIMEOUT_W-1:0] timeout_ticks;
        logic [CSIZE_W-1:0]   cluster_size;
        logic [VERSION_W-1:0] expected_version;
        logic                 force_main;
    } t_cfg;

    // table write controls
    typedef struct packed {
        logic wr_en;
        logic set_known;
    } t_tbl_ctl;

    // sequencer status toward the top level
    typedef struct packed {
        logic idle;
        logic done;
    } t_scan_sts;

endpackage

// ----- hdl/chb_if.sv -----
// Channel interfaces: heartbeat/tick input, result output and configuration writes.
interface chb_in_if;
    logic              valid;
    logic              ready;
    chb_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface chb_out_if;
    logic               valid;
    logic               ready;
    chb_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface chb_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [chb_pkg::CFG_IDX_W-1:0]    index;
    logic [chb_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/cluster_heartbeat_membership.sv -----
// Top level: configuration registers, input handshake, output register, assertions.
//
//  channel  | dir | transaction
//  ---------+-----+---------------------------------------------------------
//  i_in     | in  | heartbeat (op 0) or one-second tick (op 1)
//  o_out    | out | accepted, active_count, svc_busy, start_request, timeouts
//  i_cfg    | in  | register index + data, always ready
//
// The scan issues a table read for every entry through the single read port, folds in
// the registered read data of each, including the last, then reaches done and loads
// the output register. The next item is accepted once the sequencer is idle again.
// Reset clears all known bits together; no clearing pass is needed.
// A finished result sits in the output register, so the next item is taken while it
// waits; a full output register holds the sequencer in done until the hand-off.
module cluster_heartbeat_membership #(
    parameter int NODES = chb_pkg::NODES_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    chb_in_if.sink     i_in,
    chb_out_if.source  o_out,
    chb_cfg_if.sink    i_cfg
);
    chb_pkg::t_cfg      r_cfg;
    chb_pkg::t_scan_sts sts;
    chb_pkg::t_out_item result;
    chb_pkg::t_out_item r_out;
    logic               r_out_valid;
    logic               start;
    logic               take;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.my_node_id       <= chb_pkg::RST_MY_NODE_ID;
            r_cfg.timeout_ticks    <= chb_pkg::RST_TIMEOUT_TICKS;
            r_cfg.cluster_size     <= chb_pkg::RST_CLUSTER_SIZE;
            r_cfg.expected_version <= chb_pkg::RST_EXPECTED_VERSION;
            r_cfg.force_main       <= chb_pkg::RST_FORCE_MAIN;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                chb_pkg::REG_MY_NODE_ID:
                    r_cfg.my_node_id <= i_cfg.data[chb_pkg::NODE_ID_W-1:0];
                chb_pkg::REG_TIMEOUT_TICKS:
                    r_cfg.timeout_ticks <= i_cfg.data[chb_pkg::TIMEOUT_W-1:0];
                chb_pkg::REG_CLUSTER_SIZE:
                    r_cfg.cluster_size <= i_cfg.data[chb_pkg::CSIZE_W-1:0];
                chb_pkg::REG_EXPECTED_VERSION:
                    r_cfg.expected_version <= i_cfg.data[chb_pkg::VERSION_W-1:0];
                chb_pkg::REG_FORCE_MAIN:
                    r_cfg.force_main <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = sts.idle;
    assign start      = i_in.valid && sts.idle;
    assign take       = sts.done && (!r_out_valid || o_out.ready);

    chb_scan #(.NODES(NODES)) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_in.payload),
        .i_cfg    (r_cfg),
        .i_take   (take),
        .o_sts    (sts),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= result;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> !sts.idle)
        else $error("sequencer idle right after an accepted transaction");

    a_done_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.done |-> !sts.idle)
        else $error("sequencer reports done and idle together");

    a_heartbeat_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.accepted) |-> (!r_out.start_request && r_out.newly_timed_out == '0))
        else $error("stored heartbeat carries tick-only results");

    a_start_no_services: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.start_request) |-> !r_out.svc_busy)
        else $error("start request while services are up");

endmodule

// ----- hdl/chb_table.sv -----
// Membership table: status/last-seen memory plus per-entry known bits.
module chb_table #(
    parameter int NODES = chb_pkg::NODES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  chb_pkg::t_tbl_ctl             i_ctl,
    input  logic [$clog2(NODES)-1:0]      i_wr_addr,
    input  logic [chb_pkg::STATUS_W-1:0]  i_wr_status,
    input  logic [chb_pkg::TIME_W-1:0]    i_wr_seen,
    input  logic [$clog2(NODES)-1:0]      i_rd_addr,
    output logic                          o_rd_known,
    output logic [chb_pkg::STATUS_W-1:0]  o_rd_status,
    output logic [chb_pkg::TIME_W-1:0]    o_rd_seen
);
    localparam int WW = chb_pkg::STATUS_W + chb_pkg::TIME_W;

    logic [WW-1:0]    r_mem [NODES];
    logic [WW-1:0]    r_rd_word;
    logic [NODES-1:0] r_known;
    logic             r_rd_known;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_status, i_wr_seen};
        end
        r_rd_word <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known    <= '0;
            r_rd_known <= 1'b0;
        end else begin
            if (i_ctl.wr_en && i_ctl.set_known) begin
                r_known[i_wr_addr] <= 1'b1;
            end
            r_rd_known <= r_known[i_rd_addr];
        end
    end

    assign o_rd_known  = r_rd_known;
    assign o_rd_status = r_rd_word[WW-1 -: chb_pkg::STATUS_W];
    assign o_rd_seen   = r_rd_word[chb_pkg::TIME_W-1:0];

endmodule

// ----- hdl/chb_scan.sv -----
// Item sequencer: heartbeat store, table scan with timeout write-back, counts and election.
module chb_scan #(
    parameter int NODES = chb_pkg::NODES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  chb_pkg::t_in_item  i_item,
    input  chb_pkg::t_cfg      i_cfg,
    input  logic               i_take,
    output chb_pkg::t_scan_sts o_sts,
    output chb_pkg::t_out_item o_result
);
    localparam int IW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam int MW = (IW > chb_pkg::NODE_ID_W) ? IW : chb_pkg::NODE_ID_W;
    localparam int QW = (CW > chb_pkg::COUNT_W) ? CW : chb_pkg::COUNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                    r_state;
    logic                          r_op;
    logic [chb_pkg::STATUS_W-1:0]  r_local;
    logic                          r_acc;
    logic [chb_pkg::TIME_W-1:0]    r_now;
    logic [IW:0]                   r_rd_idx;
    logic                          r_pv;
    logic [IW-1:0]                 r_pidx;
    logic [CW-1:0]                 r_active;
    logic [CW-1:0]                 r_ntimed;
    logic                          r_up;
    logic                          r_found;
    logic                          r_lead_ok;

    chb_pkg::t_tbl_ctl             tbl_ctl;
    logic [IW-1:0]                 wr_addr;
    logic [chb_pkg::STATUS_W-1:0]  wr_status;
    logic [chb_pkg::TIME_W-1:0]    wr_seen;
    logic [IW-1:0]                 rd_addr;
    logic                          rd_known;
    logic [chb_pkg::STATUS_W-1:0]  rd_status;
    logic [chb_pkg::TIME_W-1:0]    rd_seen;

    logic                          hb_ok;
    logic                          issue;
    logic [chb_pkg::TIME_W-1:0]    silence;
    logic                          timed;
    logic [chb_pkg::STATUS_W-1:0]  st_eff;
    logic                          is_active;
    logic                          is_svc;
    logic                          is_cand;
    logic [QW-1:0]                 active_ext;
    logic [QW-1:0]                 ntimed_ext;
    logic [QW-1:0]                 quorum_need;
    logic                          quorum_ok;

    assign hb_ok = (i_item.op == chb_pkg::OP_HEARTBEAT)
                && (i_item.msg_version == i_cfg.expected_version)
                && (32'(i_item.node_id) < 32'(NODES));

    assign rd_addr = r_rd_idx[IW-1:0];
    assign issue   = (r_state == S_SCAN) && (r_rd_idx != (IW+1)'(NODES));

    // modulo-2^32 silence against the timeout, own entry exempt
    assign silence = r_now - rd_seen;
    assign timed   = (r_op == chb_pkg::OP_TICK) && r_pv && rd_known
                  && (MW'(r_pidx) != MW'(i_cfg.my_node_id))
                  && (rd_status != chb_pkg::ST_TIMEDOUT)
                  && (silence > 32'(i_cfg.timeout_ticks));
    assign st_eff  = timed ? chb_pkg::ST_TIMEDOUT : rd_status;

    assign is_active = rd_known && (st_eff <= chb_pkg::ST_ERRORED);
    assign is_svc    = rd_known && (st_eff inside {chb_pkg::ST_RUNNING, chb_pkg::ST_STOPPING,
                                                   chb_pkg::ST_STARTING});
    assign is_cand   = rd_known && (st_eff inside {chb_pkg::ST_INITIAL, chb_pkg::ST_STANDBY});

    // write port: heartbeat store at acceptance, timeout write-back during the scan
    always_comb begin
        if (r_state == S_IDLE) begin
            tbl_ctl.wr_en     = i_start && hb_ok;
            tbl_ctl.set_known = 1'b1;
            wr_addr           = IW'(i_item.node_id);
            wr_status         = i_item.node_status;
            wr_seen           = r_now;
        end else begin
            tbl_ctl.wr_en     = timed;
            tbl_ctl.set_known = 1'b0;
            wr_addr           = r_pidx;
            wr_status         = chb_pkg::ST_TIMEDOUT;
            wr_seen           = rd_seen;
        end
    end

    chb_table #(.NODES(NODES)) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (tbl_ctl),
        .i_wr_addr   (wr_addr),
        .i_wr_status (wr_status),
        .i_wr_seen   (wr_seen),
        .i_rd_addr   (rd_addr),
        .o_rd_known  (rd_known),
        .o_rd_status (rd_status),
        .o_rd_seen   (rd_seen)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_now    <= '0;
            r_pv     <= 1'b0;
            r_rd_idx <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_rd_idx <= '0;
                        r_pv     <= 1'b0;
                        r_state  <= S_SCAN;
                        if (i_item.op == chb_pkg::OP_TICK) begin
                            r_now <= r_now + chb_pkg::TIME_W'(1);
                        end
                    end
                end
                S_SCAN: begin
                    r_pv <= issue;
                    if (issue) begin
                        r_rd_idx <= r_rd_idx + (IW+1)'(1);
                    end else if (!r_pv) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // per-item accumulators, cleared when a new item is accepted
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            if (i_start) begin
                r_op      <= i_item.op;
                r_local   <= i_item.local_status;
                r_acc     <= hb_ok;
                r_active  <= '0;
                r_ntimed  <= '0;
                r_up      <= 1'b0;
                r_found   <= 1'b0;
                r_lead_ok <= 1'b0;
            end
        end else if (r_pv) begin
            r_active <= r_active + CW'(is_active);
            r_ntimed <= r_ntimed + CW'(timed);
            r_up     <= r_up | is_svc;
            if (!r_found && is_cand) begin
                r_found   <= 1'b1;
                r_lead_ok <= (st_eff == chb_pkg::ST_STANDBY)
                          && (MW'(r_pidx) == MW'(i_cfg.my_node_id));
            end
        end
        r_pidx <= rd_addr;
    end

    assign active_ext  = QW'(r_active);
    assign ntimed_ext  = QW'(r_ntimed);
    assign quorum_need = QW'(i_cfg.cluster_size >> 1) + QW'(1);
    assign quorum_ok   = (i_cfg.cluster_size <= chb_pkg::CSIZE_W'(2))
                      || (active_ext >= quorum_need);

    always_comb begin
        o_result.accepted        = r_acc;
        o_result.active_count    = (active_ext > QW'(chb_pkg::COUNT_SAT)) ? chb_pkg::COUNT_SAT
                                 : active_ext[chb_pkg::COUNT_W-1:0];
        o_result.svc_busy        = r_up;
        o_result.newly_timed_out = (ntimed_ext > QW'(chb_pkg::COUNT_SAT)) ? chb_pkg::COUNT_SAT
                                 : ntimed_ext[chb_pkg::COUNT_W-1:0];
        o_result.start_request   = (r_op == chb_pkg::OP_TICK) && !i_cfg.force_main
                                 && (r_local == chb_pkg::ST_STANDBY) && quorum_ok
                                 && !r_up && r_found && r_lead_ok;
    end

    assign o_sts.idle = (r_state == S_IDLE);
    assign o_sts.done = (r_state == S_DONE);

endmodule
